// ===== rtl/core/skds_pkg.sv =====
// ----------------------------------------------------------------------------
// skds_pkg: shared types for the smallest distinct value selector
// Word width, configuration width, and the structs that travel along the
// chain of sorting cells.
// ----------------------------------------------------------------------------
package skds_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned CFG_W  = 7;

	// A value that walks down the chain looking for its place.
	typedef struct packed {
		logic              vld;
		logic [WORD_W-1:0] val;
	} skds_tok_t;

	// A value held in a cell of the sorted store.
	typedef struct packed {
		logic              vld;
		logic [WORD_W-1:0] val;
	} skds_ent_t;

	// Per-cell control from the sequencer.
	typedef struct packed {
		logic en;     // Cell lies inside the current capacity.
		logic shift;  // Move the store one cell toward the output.
		logic trim;   // A new word enters; cells outside the capacity let go.
	} skds_ctrl_t;

endpackage

// ===== rtl/core/skds_cell.sv =====
// ----------------------------------------------------------------------------
// skds_cell: one cell of the sorted insertion chain
// Holds one entry of the store. A value arriving from the left is kept,
// dropped as a duplicate, swapped with the entry, or passed on to the right.
// In shift mode the cell takes the entry of its right neighbor. A cell outside
// the capacity drops arriving values and clears its entry when a word enters.
// ----------------------------------------------------------------------------
module skds_cell
	import skds_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  skds_ctrl_t ctrl,
	input  skds_tok_t  tok_in,
	input  skds_ent_t  right_in,
	output skds_tok_t  tok_out,
	output skds_ent_t  ent
);

	logic              ent_vld_q;
	logic [WORD_W-1:0] ent_val_q;
	logic              tok_vld_q;
	logic [WORD_W-1:0] tok_val_q;
	logic              ent_vld_d;
	logic [WORD_W-1:0] ent_val_d;
	logic              tok_vld_d;
	logic [WORD_W-1:0] tok_val_d;
	logic              less;

	assign less = $signed(tok_in.val) < $signed(ent_val_q);

	// Compare the arriving value with the held entry.
	always_comb begin
		ent_vld_d = ent_vld_q;
		ent_val_d = ent_val_q;
		tok_vld_d = 1'b0;
		tok_val_d = tok_in.val;
		if (ctrl.shift) begin
			ent_vld_d = right_in.vld;
			ent_val_d = right_in.val;
		end else if (!ctrl.en) begin
			if (ctrl.trim) begin
				ent_vld_d = 1'b0;
			end
		end else if (tok_in.vld) begin
			if (!ent_vld_q) begin
				ent_vld_d = 1'b1;
				ent_val_d = tok_in.val;
			end else if (ent_val_q == tok_in.val) begin
				tok_vld_d = 1'b0;
			end else if (less) begin
				ent_val_d = tok_in.val;
				tok_vld_d = 1'b1;
				tok_val_d = ent_val_q;
			end else begin
				tok_vld_d = 1'b1;
			end
		end
	end

	// Valid bits reset; values need none.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= 1'b0;
			tok_vld_q <= 1'b0;
		end else begin
			ent_vld_q <= ent_vld_d;
			tok_vld_q <= tok_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		ent_val_q <= ent_val_d;
		tok_val_q <= tok_val_d;
	end

	assign tok_out = '{vld: tok_vld_q, val: tok_val_q};
	assign ent     = '{vld: ent_vld_q, val: ent_val_q};

endmodule

// ===== rtl/core/smallest_k_distinct_select_core.sv =====
// ----------------------------------------------------------------------------
// smallest_k_distinct_select_core: smallest distinct values of a data set
// Channel | dir | word fields (low bit up)
// s_*     | in  | tdata: value[31:0]; tlast: set_end
// m_*     | out | tdata: smallest_value[31:0]; tlast: final_result
// cfg_*   | in  | cfg_wdata: select_count[6:0]
// Values of a set are taken one per cycle; each walks the cell chain one
// cell per cycle. After the set_end word the chain drains in the drain phase,
// then one result leaves per cycle while m_tready is high, as the store
// shifts to cell 0. No input word is taken during the drain and output phases.
// Reset clears all cell valid bits at once; select_count resets to 64.
// ----------------------------------------------------------------------------
module smallest_k_distinct_select_core
	import skds_pkg::*;
#(
	parameter int unsigned MAX_SELECT = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [WORD_W-1:0] s_tdata,   // value[31:0]
	input  logic              s_tlast,   // set_end
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [WORD_W-1:0] m_tdata,   // smallest_value[31:0]
	output logic              m_tlast,   // final_result
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata  // select_count[6:0]
);

	localparam int unsigned DR_W = (MAX_SELECT > 1) ? $clog2(MAX_SELECT) : 1;

	localparam logic [1:0] ST_RUN   = 2'd0;
	localparam logic [1:0] ST_DRAIN = 2'd1;
	localparam logic [1:0] ST_OUT   = 2'd2;

	logic [1:0]       state_q;
	logic [DR_W-1:0]  drain_q;
	logic [CFG_W-1:0] sel_q;
	logic [CFG_W-1:0] cap;
	logic             s_acc;
	logic             m_acc;

	skds_tok_t tok [0:MAX_SELECT];
	skds_ent_t ent [0:MAX_SELECT];

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= CFG_W'(64);
		end else if (cfg_we) begin
			sel_q <= cfg_wdata;
		end
	end

	// Clamp the count into one to MAX_SELECT.
	always_comb begin
		cap = sel_q;
		if (sel_q == '0) begin
			cap = CFG_W'(1);
		end else if (sel_q > CFG_W'(MAX_SELECT)) begin
			cap = CFG_W'(MAX_SELECT);
		end
	end

	assign s_tready = (state_q == ST_RUN);
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = (state_q == ST_OUT) && ent[0].vld;
	assign m_acc    = m_tvalid && m_tready;
	assign m_tdata  = ent[0].val;
	assign m_tlast  = !ent[1].vld;

	// Phase sequencer: run, drain the chain, then unload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			drain_q <= '0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (s_acc && s_tlast) begin
						state_q <= ST_DRAIN;
						drain_q <= DR_W'(MAX_SELECT - 1);
					end
				end
				ST_DRAIN: begin
					if (drain_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						drain_q <= drain_q - DR_W'(1);
					end
				end
				ST_OUT: begin
					if (m_acc && m_tlast) begin
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	// Chain ends: new words enter cell 0, an empty entry enters from the right.
	assign tok[0]          = '{vld: s_acc, val: s_tdata};
	assign ent[MAX_SELECT] = '0;

	for (genvar i = 0; i < MAX_SELECT; i++) begin : g_cell
		skds_ctrl_t ctrl;

		assign ctrl = '{en: (CFG_W'(i) < cap), shift: m_acc, trim: s_acc};

		skds_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.tok_in   (tok[i]),
			.right_in (ent[i+1]),
			.tok_out  (tok[i+1]),
			.ent      (ent[i])
		);
	end

`ifndef ASSERT_OFF
	a_out_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (state_q == ST_OUT))
		else $error("result word offered outside the output phase");

	a_no_tok_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> !tok[MAX_SELECT].vld)
		else $error("value still in flight during output phase");

	a_set_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_acc && m_tlast) |=> (s_tready && !ent[0].vld))
		else $error("store not empty after final result");

	a_out_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DRAIN) && (drain_q == '0)) |=> ent[0].vld)
		else $error("output phase entered with an empty store");
`endif

endmodule
